// File: hdl/salcc_pkg.sv
// Shared types and constants for the set-associative LRU locality classifier.
// No dependencies; used by every module of the block.
package salcc_pkg;

  localparam int unsigned MaxSets      = 64;
  localparam int unsigned MaxWays      = 8;
  localparam int unsigned MaxLineWords = 16;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned TagW   = 30;
  localparam int unsigned SetW   = $clog2(MaxSets);
  localparam int unsigned WayW   = $clog2(MaxWays);
  localparam int unsigned WordW  = $clog2(MaxLineWords);
  localparam int unsigned OffW   = 6;
  localparam int unsigned CntW   = 32;
  localparam int unsigned WaysW  = 4;
  localparam int unsigned CfgW   = 4;
  localparam int unsigned CfgIdxW = 2;

  // Clamp limits of the configuration
  localparam logic [2:0] SetLog2Max  = 3'(SetW);
  localparam logic [2:0] LineLog2Min = 3'd2;
  localparam logic [2:0] LineLog2Max = 3'(WordW + 2);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SET_LOG2  = 2'd0,
    CFG_WAYS      = 2'd1,
    CFG_LINE_LOG2 = 2'd2,
    CFG_RSVD      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUT_MISS      = 2'd0,
    OUT_SPATIAL   = 2'd1,
    OUT_TEMPORAL  = 2'd2,
    OUT_MISALIGN  = 2'd3
  } outcome_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } back_st_e;

  // Decoded fetch travelling from the front to the back
  typedef struct packed {
    logic              misaligned;
    logic [TagW-1:0]   tag;
    logic [SetW-1:0]   set_idx;
    logic [OffW-1:0]   offset;
    logic [WordW-1:0]  word;
    logic [WaysW-1:0]  ways;
  } item_t;

  // One set: all ways side by side
  typedef struct packed {
    logic [MaxWays-1:0][TagW-1:0]         tag;
    logic [MaxWays-1:0][MaxLineWords-1:0] touched;
    logic [MaxWays-1:0]                   valid;
    logic [MaxWays-1:0][WayW-1:0]         age;
  } row_t;

endpackage

// File: hdl/salcc_front.sv
// Front end: decodes a fetch address into tag, set, offset and word.
// Depends on salcc_pkg.
module salcc_front (
  input  logic [salcc_pkg::AddrW-1:0] address_i,
  input  logic [2:0]                  set_log2_i,
  input  logic [3:0]                  ways_i,
  input  logic [2:0]                  line_log2_i,
  output salcc_pkg::item_t            item_o
);

  logic [2:0]  sl, ll;
  logic [3:0]  ways;
  logic [31:0] off_full, set_full, tag_full;

  always_comb begin
    sl = (set_log2_i > salcc_pkg::SetLog2Max) ? salcc_pkg::SetLog2Max : set_log2_i;
    ll = line_log2_i;
    if (ll < salcc_pkg::LineLog2Min) ll = salcc_pkg::LineLog2Min;
    if (ll > salcc_pkg::LineLog2Max) ll = salcc_pkg::LineLog2Max;
    ways = ways_i;
    if (ways == 4'd0) ways = 4'd1;
    if (ways > 4'(salcc_pkg::MaxWays)) ways = 4'(salcc_pkg::MaxWays);

    off_full = address_i & ((32'd1 << ll) - 32'd1);
    set_full = (address_i >> ll) & ((32'd1 << sl) - 32'd1);
    tag_full = address_i >> ({1'b0, sl} + {1'b0, ll});

    item_o.misaligned = (address_i[1:0] != 2'b00);
    item_o.tag        = tag_full[salcc_pkg::TagW-1:0];
    item_o.set_idx    = set_full[salcc_pkg::SetW-1:0];
    item_o.offset     = off_full[salcc_pkg::OffW-1:0];
    item_o.word       = off_full[salcc_pkg::WordW+1:2];
    item_o.ways       = ways;
  end

endmodule

// File: hdl/salcc_queue.sv
// Two-entry item queue between front and back.
// Depends on salcc_pkg.
module salcc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  salcc_pkg::item_t push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output salcc_pkg::item_t item_o
);

  salcc_pkg::item_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_item_i;
  end

endmodule

// File: hdl/salcc_back.sv
// Back end: set memory, lookup, LRU update, totals and output register.
// Depends on salcc_pkg.
module salcc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  salcc_pkg::item_t           q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 outcome_o,
  output logic [salcc_pkg::TagW-1:0] tag_value_o,
  output logic [salcc_pkg::SetW-1:0] set_index_o,
  output logic [salcc_pkg::OffW-1:0] byte_offset_o,
  output logic [salcc_pkg::WayW-1:0] way_used_o,
  output logic [salcc_pkg::CntW-1:0] reference_number_o,
  output logic [salcc_pkg::CntW-1:0] hit_total_o,
  output logic [salcc_pkg::CntW-1:0] temporal_total_o,
  output logic [salcc_pkg::CntW-1:0] spatial_total_o,
  output logic [salcc_pkg::CntW-1:0] miss_total_o,
  output logic [salcc_pkg::CntW-1:0] access_total_o,
  output logic [salcc_pkg::CntW-1:0] hit_cnt_o,
  output logic [salcc_pkg::CntW-1:0] temp_cnt_o,
  output logic [salcc_pkg::CntW-1:0] spat_cnt_o
);

  localparam logic [31:0] Sat = '1;

  salcc_pkg::back_st_e st_q, st_d;
  salcc_pkg::row_t     row_mem [salcc_pkg::MaxSets];
  salcc_pkg::row_t     rd_row_q, cur_row, new_row;
  salcc_pkg::item_t    item_q;
  logic [salcc_pkg::MaxSets-1:0] row_init_q;

  logic [31:0] hit_q, temp_q, spat_q, miss_q, acc_q, ref_q;
  logic        out_valid_q;
  logic [1:0]  outcome_q;
  logic [salcc_pkg::TagW-1:0] tag_q;
  logic [salcc_pkg::SetW-1:0] set_q;
  logic [salcc_pkg::OffW-1:0] off_q;
  logic [salcc_pkg::WayW-1:0] way_q;
  logic [31:0] refo_q, hito_q, tempo_q, spato_q, misso_q, acco_q;

  logic slot_free, rd_en, load_mis, load_eval;
  logic hit, inv_found, temporal;
  logic [salcc_pkg::WayW-1:0] hit_way, inv_way, old_way, way;
  logic [salcc_pkg::WayW-1:0] rank;
  logic [1:0] outcome;
  logic [31:0] hit_n, temp_n, spat_n, miss_n, acc_n;

  assign slot_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      salcc_pkg::ST_IDLE: if (q_valid_i && !q_item_i.misaligned) st_d = salcc_pkg::ST_EVAL;
      salcc_pkg::ST_EVAL: if (slot_free) st_d = salcc_pkg::ST_IDLE;
      default:            st_d = salcc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    rd_en     = 1'b0;
    load_mis  = 1'b0;
    load_eval = 1'b0;
    unique case (st_q)
      salcc_pkg::ST_IDLE: begin
        rd_en    = q_valid_i && !q_item_i.misaligned;
        load_mis = q_valid_i && q_item_i.misaligned && slot_free;
      end
      salcc_pkg::ST_EVAL: load_eval = slot_free;
      default: ;
    endcase
    q_pop_o = rd_en || load_mis;
  end

  // lookup and replacement
  always_comb begin
    cur_row = rd_row_q;
    if (!row_init_q[item_q.set_idx]) begin
      cur_row.valid = '0;
      for (int w = 0; w < salcc_pkg::MaxWays; w++) cur_row.age[w] = salcc_pkg::WayW'(w);
    end
    hit = 1'b0; hit_way = '0; inv_found = 1'b0; inv_way = '0; old_way = '0;
    for (int w = 0; w < salcc_pkg::MaxWays; w++) begin
      if (!hit && (4'(w) < item_q.ways) && cur_row.valid[w] && cur_row.tag[w] == item_q.tag) begin
        hit = 1'b1; hit_way = salcc_pkg::WayW'(w);
      end
      if (!inv_found && (4'(w) < item_q.ways) && !cur_row.valid[w]) begin
        inv_found = 1'b1; inv_way = salcc_pkg::WayW'(w);
      end
    end
    for (int w = 1; w < salcc_pkg::MaxWays; w++) begin
      if ((4'(w) < item_q.ways) && cur_row.age[w] > cur_row.age[old_way])
        old_way = salcc_pkg::WayW'(w);
    end
    way      = hit ? hit_way : (inv_found ? inv_way : old_way);
    temporal = cur_row.touched[hit_way][item_q.word];
    outcome  = !hit ? salcc_pkg::OUT_MISS :
               (temporal ? salcc_pkg::OUT_TEMPORAL : salcc_pkg::OUT_SPATIAL);

    new_row = cur_row;
    if (hit) begin
      new_row.touched[way][item_q.word] = 1'b1;
    end else begin
      new_row.valid[way]   = 1'b1;
      new_row.tag[way]     = item_q.tag;
      new_row.touched[way] = salcc_pkg::MaxLineWords'(1) << item_q.word;
    end
    rank = cur_row.age[way];
    for (int w = 0; w < salcc_pkg::MaxWays; w++)
      if (cur_row.age[w] < rank) new_row.age[w] = cur_row.age[w] + 1'b1;
    new_row.age[way] = '0;

    hit_n  = (hit && hit_q != Sat) ? hit_q + 32'd1 : hit_q;
    temp_n = (hit && temporal && temp_q != Sat) ? temp_q + 32'd1 : temp_q;
    spat_n = (hit && !temporal && spat_q != Sat) ? spat_q + 32'd1 : spat_q;
    miss_n = (!hit && miss_q != Sat) ? miss_q + 32'd1 : miss_q;
    acc_n  = (acc_q != Sat) ? acc_q + 32'd1 : acc_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_eval) row_mem[item_q.set_idx] <= new_row;
    if (rd_en) begin
      rd_row_q <= row_mem[q_item_i.set_idx];
      item_q   <= q_item_i;
    end
    if (load_mis) begin
      outcome_q <= salcc_pkg::OUT_MISALIGN;
      tag_q     <= q_item_i.tag;
      set_q     <= q_item_i.set_idx;
      off_q     <= q_item_i.offset;
      way_q     <= '0;
      refo_q    <= '0;
      hito_q    <= hit_q;
      tempo_q   <= temp_q;
      spato_q   <= spat_q;
      misso_q   <= miss_q;
      acco_q    <= acc_q;
    end else if (load_eval) begin
      outcome_q <= outcome;
      tag_q     <= item_q.tag;
      set_q     <= item_q.set_idx;
      off_q     <= item_q.offset;
      way_q     <= way;
      refo_q    <= ref_q;
      hito_q    <= hit_n;
      tempo_q   <= temp_n;
      spato_q   <= spat_n;
      misso_q   <= miss_n;
      acco_q    <= acc_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= salcc_pkg::ST_IDLE;
      row_init_q  <= '0;
      out_valid_q <= 1'b0;
      hit_q  <= '0; temp_q <= '0; spat_q <= '0; miss_q <= '0; acc_q <= '0;
      ref_q  <= 32'd1;
    end else begin
      st_q <= st_d;
      if (load_mis || load_eval) out_valid_q <= 1'b1;
      else if (!out_stall_i)     out_valid_q <= 1'b0;
      if (load_eval) begin
        row_init_q[item_q.set_idx] <= 1'b1;
        hit_q  <= hit_n; temp_q <= temp_n; spat_q <= spat_n;
        miss_q <= miss_n; acc_q <= acc_n;
        ref_q  <= (ref_q != Sat) ? ref_q + 32'd1 : ref_q;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign outcome_o          = outcome_q;
  assign tag_value_o        = tag_q;
  assign set_index_o        = set_q;
  assign byte_offset_o      = off_q;
  assign way_used_o         = way_q;
  assign reference_number_o = refo_q;
  assign hit_total_o        = hito_q;
  assign temporal_total_o   = tempo_q;
  assign spatial_total_o    = spato_q;
  assign miss_total_o       = misso_q;
  assign access_total_o     = acco_q;
  assign hit_cnt_o          = hit_q;
  assign temp_cnt_o         = temp_q;
  assign spat_cnt_o         = spat_q;

endmodule

// File: hdl/set_assoc_lru_cache_locality_classifier_core.sv
// An aligned item is read from set memory, then evaluated, written back and output;
// a misaligned one goes from the queue straight to the output register. Nothing is
// taken while an aligned item is evaluated; misaligned items pass at one per cycle
// while the output is not stalled. Reset: asynchronous, active low; clears valid and
// LRU state via a per-set init flag (no clearing pass); totals reset to 0, ref_q to 1.
// Top level: config registers, front decode, item queue, back end. Uses salcc_pkg.
module set_assoc_lru_cache_locality_classifier_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [salcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [salcc_pkg::CfgW-1:0] cfg_data_i,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [salcc_pkg::AddrW-1:0] address_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 outcome_o,
  output logic [salcc_pkg::TagW-1:0] tag_value_o,
  output logic [salcc_pkg::SetW-1:0] set_index_o,
  output logic [salcc_pkg::OffW-1:0] byte_offset_o,
  output logic [salcc_pkg::WayW-1:0] way_used_o,
  output logic [salcc_pkg::CntW-1:0] reference_number_o,
  output logic [salcc_pkg::CntW-1:0] hit_total_o,
  output logic [salcc_pkg::CntW-1:0] temporal_total_o,
  output logic [salcc_pkg::CntW-1:0] spatial_total_o,
  output logic [salcc_pkg::CntW-1:0] miss_total_o,
  output logic [salcc_pkg::CntW-1:0] access_total_o
);

  logic [2:0] set_log2_q, line_log2_q;
  logic [3:0] ways_q;

  salcc_pkg::item_t dec_item, q_item;
  logic q_full, q_valid, q_pop, push;
  logic [salcc_pkg::CntW-1:0] hit_cnt, temp_cnt, spat_cnt;

  // config port never blocks
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_log2_q  <= 3'd4;
      ways_q      <= 4'd2;
      line_log2_q <= 3'd4;
    end else if (cfg_valid_i) begin
      case (salcc_pkg::cfg_idx_e'(cfg_index_i))
        salcc_pkg::CFG_SET_LOG2:  set_log2_q  <= cfg_data_i[2:0];
        salcc_pkg::CFG_WAYS:      ways_q      <= cfg_data_i;
        salcc_pkg::CFG_LINE_LOG2: line_log2_q <= cfg_data_i[2:0];
        default: ;  // reserved index: ignored
      endcase
    end
  end

  // items enter the queue straight from the decoder
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  salcc_front u_front (
    .address_i   (address_i),
    .set_log2_i  (set_log2_q),
    .ways_i      (ways_q),
    .line_log2_i (line_log2_q),
    .item_o      (dec_item)
  );

  salcc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (dec_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  salcc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_item_i           (q_item),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .outcome_o          (outcome_o),
    .tag_value_o        (tag_value_o),
    .set_index_o        (set_index_o),
    .byte_offset_o      (byte_offset_o),
    .way_used_o         (way_used_o),
    .reference_number_o (reference_number_o),
    .hit_total_o        (hit_total_o),
    .temporal_total_o   (temporal_total_o),
    .spatial_total_o    (spatial_total_o),
    .miss_total_o       (miss_total_o),
    .access_total_o     (access_total_o),
    .hit_cnt_o          (hit_cnt),
    .temp_cnt_o         (temp_cnt),
    .spat_cnt_o         (spat_cnt)
  );

  // misaligned results carry no way and no reference number
  a_misalign_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == salcc_pkg::OUT_MISALIGN |->
      way_used_o == '0 && reference_number_o == '0)
    else $error("misaligned result with nonzero way or reference");

  // every temporal or spatial hit is also a hit
  a_hit_ge_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_cnt >= temp_cnt && hit_cnt >= spat_cnt)
    else $error("hit total below a hit class total");

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("push into full queue");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the set-associative LRU locality classifier core.
// Depends on salcc_pkg and the core RTL; predicts every result in-line.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned IdleLimit = 20000;
  localparam logic [31:0] Sat = 32'hFFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [salcc_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [salcc_pkg::CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [salcc_pkg::AddrW-1:0] address_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] outcome_o;
  logic [salcc_pkg::TagW-1:0] tag_value_o;
  logic [salcc_pkg::SetW-1:0] set_index_o;
  logic [salcc_pkg::OffW-1:0] byte_offset_o;
  logic [salcc_pkg::WayW-1:0] way_used_o;
  logic [salcc_pkg::CntW-1:0] reference_number_o, hit_total_o, temporal_total_o;
  logic [salcc_pkg::CntW-1:0] spatial_total_o, miss_total_o, access_total_o;

  always #5 clk_i = ~clk_i;

  set_assoc_lru_cache_locality_classifier_core dut (.*);

  // One expected lookup result
  typedef struct {
    salcc_pkg::outcome_e outcome;
    logic [29:0] tag;
    logic [5:0]  set_idx;
    logic [5:0]  offset;
    logic [2:0]  way;
    logic [31:0] refno;
    logic [31:0] totals [5];  // hit, temporal, spatial, miss, access
  } lookup_t;

  lookup_t lookups_due[$];

  // Shadow cache
  logic        sh_valid [salcc_pkg::MaxSets][salcc_pkg::MaxWays];
  logic [29:0] sh_tag   [salcc_pkg::MaxSets][salcc_pkg::MaxWays];
  logic [2:0]  sh_age   [salcc_pkg::MaxSets][salcc_pkg::MaxWays];
  logic [15:0] sh_touch [salcc_pkg::MaxSets][salcc_pkg::MaxWays];
  logic [31:0] sh_next_ref;
  logic [31:0] sh_totals [5];
  logic [2:0]  sh_set_log2 = 3'd4;
  logic [3:0]  sh_ways = 4'd2;
  logic [2:0]  sh_line_log2 = 3'd4;

  int errors = 0;
  int n_sent = 0, n_checked = 0, n_hits = 0, n_misalign = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit gaps_on = 1'b1;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == Sat) ? v : v + 32'd1;
  endfunction

  // Predict the result of one fetch address and update the shadow cache
  function automatic lookup_t classify_fetch(logic [31:0] addr);
    lookup_t r;
    int sl, ll, nw, s, w, hit_w, pick, wd;
    logic [2:0] rank;
    sl = (sh_set_log2 > 6) ? 6 : sh_set_log2;
    ll = (sh_line_log2 < 2) ? 2 : ((sh_line_log2 > 6) ? 6 : sh_line_log2);
    nw = (sh_ways < 1) ? 1 :
         ((sh_ways > salcc_pkg::MaxWays) ? salcc_pkg::MaxWays : sh_ways);
    r.offset  = 6'(addr & ((32'd1 << ll) - 1));
    s         = int'((addr >> ll) & ((32'd1 << sl) - 1));
    r.set_idx = 6'(s);
    r.tag     = (sl + ll >= 32) ? '0 : 30'(addr >> (sl + ll));
    wd        = r.offset >> 2;
    r.way     = '0;
    r.refno   = '0;
    if (addr[1:0] != 2'b00) begin
      r.outcome = salcc_pkg::OUT_MISALIGN;
    end else begin
      hit_w = -1;
      for (w = 0; w < nw; w++)
        if (hit_w < 0 && sh_valid[s][w] && sh_tag[s][w] == r.tag) hit_w = w;
      if (hit_w >= 0) begin
        pick = hit_w;
        if (sh_touch[s][pick][wd]) begin
          r.outcome = salcc_pkg::OUT_TEMPORAL;
          sh_totals[1] = sat_inc(sh_totals[1]);
        end else begin
          r.outcome = salcc_pkg::OUT_SPATIAL;
          sh_totals[2] = sat_inc(sh_totals[2]);
        end
        sh_totals[0] = sat_inc(sh_totals[0]);
        sh_touch[s][pick][wd] = 1'b1;
      end else begin
        pick = -1;
        for (w = 0; w < nw; w++)
          if (pick < 0 && !sh_valid[s][w]) pick = w;
        if (pick < 0) begin
          pick = 0;
          for (w = 1; w < nw; w++)
            if (sh_age[s][w] > sh_age[s][pick]) pick = w;
        end
        r.outcome = salcc_pkg::OUT_MISS;
        sh_totals[3] = sat_inc(sh_totals[3]);
        sh_valid[s][pick] = 1'b1;
        sh_tag[s][pick] = r.tag;
        sh_touch[s][pick] = 16'd1 << wd;
      end
      // LRU promote
      rank = sh_age[s][pick];
      for (w = 0; w < salcc_pkg::MaxWays; w++)
        if (sh_age[s][w] < rank) sh_age[s][w]++;
      sh_age[s][pick] = '0;
      sh_totals[4] = sat_inc(sh_totals[4]);
      r.way = 3'(pick);
      r.refno = sh_next_ref;
      sh_next_ref = sat_inc(sh_next_ref);
    end
    r.totals = sh_totals;
    return r;
  endfunction

  task automatic send_fetch(logic [31:0] addr);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i  <= addr;
    lookups_due.push_back(classify_fetch(addr));
    n_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic go_quiet();
    in_valid_i <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Leaves valid high; the caller drops it after the last write
  task automatic write_reg(salcc_pkg::cfg_idx_e idx, logic [3:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      salcc_pkg::CFG_SET_LOG2:  sh_set_log2 = val[2:0];
      salcc_pkg::CFG_WAYS:      sh_ways = val;
      salcc_pkg::CFG_LINE_LOG2: sh_line_log2 = val[2:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [3:0] sl, logic [3:0] nw, logic [3:0] ll);
    go_quiet();
    write_reg(salcc_pkg::CFG_SET_LOG2, sl);
    write_reg(salcc_pkg::CFG_WAYS, nw);
    write_reg(salcc_pkg::CFG_LINE_LOG2, ll);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Address biased toward a small working set so hits and evictions happen
  function automatic logic [31:0] local_addr();
    logic [31:0] a;
    a = {20'($urandom_range(0, 11)), 12'h000} | ($urandom() & 32'h0000_0FFC);
    if ($urandom_range(0, 15) == 0) a = $urandom() & ~32'h3;
    if ($urandom_range(0, 31) == 0) a[1:0] = 2'($urandom_range(1, 3));
    return a;
  endfunction

  task automatic test_directed();
    send_fetch(32'h0000_0000);          // cold miss
    send_fetch(32'h0000_0000);          // temporal hit
    send_fetch(32'h0000_0004);          // spatial hit
    send_fetch(32'hFFFF_FFFC);          // highest aligned address
    send_fetch(32'hFFFF_FFFC);
    send_fetch(32'h0000_0001);          // misaligned variants
    send_fetch(32'h0000_0002);
    send_fetch(32'hFFFF_FFFF);
    // three tags to one set with two ways: LRU eviction
    send_fetch(32'h0000_1000);
    send_fetch(32'h0000_2000);
    send_fetch(32'h0000_0008);
    send_fetch(32'h0000_1000);
    send_fetch(32'hAAAA_AAA8);
    send_fetch(32'h5555_5554);
  endtask

  // Out-of-range register values exercise the clamps
  task automatic test_config_extremes();
    set_geometry(4'd7, 4'd0, 4'd0);
    send_fetch(32'h0000_0000);
    send_fetch(32'h0001_0000);
    send_fetch(32'h8000_0004);
    set_geometry(4'd0, 4'd15, 4'd7);
    send_fetch(32'h0000_003C);
    send_fetch(32'hFFFF_FFC0);
    send_fetch(32'h0000_0040);
  endtask

  task automatic test_random_phases();
    int p, k;
    for (p = 0; p < 10; p++) begin
      set_geometry(4'($urandom_range(0, 7)), 4'($urandom_range(0, 9)),
                   4'($urandom_range(1, 7)));
      gaps_on = (p % 3) != 2;
      for (k = 0; k < 95; k++) send_fetch(local_addr());
    end
    gaps_on = 1'b1;
  endtask

  // Receiver holds off while the sender keeps going; fills the pipe
  task automatic test_backpressure();
    int k;
    set_geometry(4'd6, 4'd8, 4'd6);
    hold_off = 1'b1;
    gaps_on = 1'b0;
    for (k = 0; k < 60; k++) send_fetch(local_addr());
    gaps_on = 1'b1;
  endtask

  // Receiver stalls: random, occasional long stretch
  initial begin : stall_gen
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_off = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    lookup_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lookups_due.size() == 0) begin
        $display("%0t: unexpected result, outcome %0d", $realtime, outcome_o);
        errors++;
      end else begin
        e = lookups_due.pop_front();
        n_checked++;
        if (e.outcome inside {salcc_pkg::OUT_SPATIAL, salcc_pkg::OUT_TEMPORAL}) n_hits++;
        if (e.outcome == salcc_pkg::OUT_MISALIGN) n_misalign++;
        if (outcome_o !== e.outcome || tag_value_o !== e.tag ||
            set_index_o !== e.set_idx || byte_offset_o !== e.offset ||
            way_used_o !== e.way || reference_number_o !== e.refno ||
            hit_total_o !== e.totals[0] || temporal_total_o !== e.totals[1] ||
            spatial_total_o !== e.totals[2] || miss_total_o !== e.totals[3] ||
            access_total_o !== e.totals[4]) begin
          errors++;
          $display("%0t: mismatch exp out=%0d tag=%h set=%0d off=%0d way=%0d ref=%0d",
                   $realtime, e.outcome, e.tag, e.set_idx, e.offset, e.way, e.refno);
          $display("   tot exp %0d %0d %0d %0d %0d", e.totals[0], e.totals[1],
                   e.totals[2], e.totals[3], e.totals[4]);
          $display("   act out=%0d tag=%h set=%0d off=%0d way=%0d ref=%0d",
                   outcome_o, tag_value_o, set_index_o, byte_offset_o, way_used_o,
                   reference_number_o);
          $display("   tot act %0d %0d %0d %0d %0d", hit_total_o, temporal_total_o,
                   spatial_total_o, miss_total_o, access_total_o);
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("set_assoc_lru_cache_locality_classifier_core regression: fail");
      $finish;
    end
  end

  initial begin : main
    int s, w;
    for (s = 0; s < salcc_pkg::MaxSets; s++)
      for (w = 0; w < salcc_pkg::MaxWays; w++) begin
        sh_valid[s][w] = 1'b0;
        sh_tag[s][w] = '0;
        sh_touch[s][w] = '0;
        sh_age[s][w] = 3'(w);
      end
    sh_next_ref = 32'd1;
    for (s = 0; s < 5; s++) sh_totals[s] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_phases();
    go_quiet();
    $display("Sent %0d and checked %0d fetches: %0d hits, %0d misaligned,",
             n_sent, n_checked, n_hits, n_misalign);
    $display("over 14 cache geometries, with a long receiver hold-off.");
    if (errors == 0 && lookups_due.size() == 0)
      $display("set_assoc_lru_cache_locality_classifier_core regression: pass");
    else
      $display("set_assoc_lru_cache_locality_classifier_core regression: fail");
    $finish;
  end
endmodule

// File: files.f
hdl/salcc_pkg.sv
hdl/salcc_front.sv
hdl/salcc_queue.sv
hdl/salcc_back.sv
hdl/set_assoc_lru_cache_locality_classifier_core.sv
tb/tb_top.sv
